@@ sv/vpz_pkg.sv @@
// ----------------------------------------------------------------------------
// vpz_pkg: shared types and constants for the viewport pan/zoom/clamp block
// Widths, event and register codes, controller states, the divider request
// and response bundles, and the constant scale-by-100 helper.
// ----------------------------------------------------------------------------
package vpz_pkg;

  // Field widths
  localparam int unsigned SCENE_W  = 14;
  localparam int unsigned SCREEN_W = 12;
  localparam int unsigned SCROLL_W = 11;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned SCALE_W  = 9;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - (4 * SCENE_W + SCALE_W + 1);

  // Divider operand widths: screen*100 over a 9-bit scale
  localparam int unsigned DIVIDEND_W = SCREEN_W + 7;
  localparam int unsigned DIVISOR_W  = SCALE_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Zoom window limits, in hundredths
  localparam int unsigned SCALE_LOW  = 50;
  localparam int unsigned SCALE_HIGH = 300;

  // Register reset values
  localparam logic [SCENE_W-1:0]  SCENE_RST    = 14'd16383;
  localparam logic [SCREEN_W-1:0] SCREEN_W_RST = 12'd640;
  localparam logic [SCREEN_W-1:0] SCREEN_H_RST = 12'd480;
  localparam logic [SCENE_W-1:0]  SIZE_RST     = 14'd50;
  localparam logic [SCALE_W-1:0]  SCALE_RST    = 9'd100;

  typedef enum logic [1:0] {
    MODE_SCROLL       = 2'd0,
    MODE_ZOOM         = 2'd1,
    MODE_FOCUS        = 2'd2,
    MODE_FOCUS_BOTTOM = 2'd3
  } vpz_mode_t;

  typedef enum logic [1:0] {
    CFG_SCENE_WIDTH   = 2'd0,
    CFG_SCENE_HEIGHT  = 2'd1,
    CFG_SCREEN_WIDTH  = 2'd2,
    CFG_SCREEN_HEIGHT = 2'd3
  } vpz_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIVW = 4'b0010,
    ST_DIVH = 4'b0100,
    ST_EXEC = 4'b1000
  } vpz_state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } vpz_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } vpz_div_rsp_t;

  // x*100 as x*64 + x*32 + x*4
  function automatic logic [DIVIDEND_W-1:0] times100(input logic [SCREEN_W-1:0] x);
    logic [DIVIDEND_W-1:0] xe;
    xe = DIVIDEND_W'(x);
    return (xe << 6) + (xe << 5) + (xe << 2);
  endfunction

endpackage

@@ sv/vpz_div.sv @@
// ----------------------------------------------------------------------------
// vpz_div: serial restoring divider
// One quotient bit per cycle; done pulses for a single cycle when the last bit is registered in the quotient.
// ----------------------------------------------------------------------------
module vpz_div import vpz_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  vpz_div_req_t req,
  output vpz_div_rsp_t rsp
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};
  assign fits    = ~diff[DIVISOR_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ sv/viewport_pan_zoom_clamp.sv @@
// ----------------------------------------------------------------------------
// viewport_pan_zoom_clamp: viewport scroll, zoom and focus controller
// Keeps a viewport rectangle and zoom scale over a configured scene and
// returns the viewport after each event on a registered result stream.
// ----------------------------------------------------------------------------
// Sequence: scroll and focus events, and zoom events out of range, go straight to the
//   update state; zoom events in range first run two 19-bit serial divisions (width,
//   then height) on the one shared divider. The update waits for a free result register.
// Each event is finished before the next one is taken.
// Reset (rst_n low, synchronous): viewport 0,0 50x50, scale 100, scene
//   16383x16383, screen 640x480; result stream empty.
module viewport_pan_zoom_clamp import vpz_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [SCENE_W-1:0]    cfg_data,
  // event requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // scroll_dx[10:0], scroll_dy[21:11],
                                            // zoom_step[29:22], focus_width[43:30],
                                            // focus_height[57:44], zero pad
  input  logic [1:0]            in_tuser,   // mode[1:0]
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // view_x[13:0], view_y[27:14],
                                            // view_w[41:28], view_h[55:42],
                                            // scale_pct[64:56], changed[65], zero pad
);

  vpz_state_t state_r, state_nxt;

  // Configuration and viewport state
  logic [SCENE_W-1:0]  scene_w_r, scene_h_r;
  logic [SCREEN_W-1:0] screen_w_r, screen_h_r;
  logic [SCENE_W-1:0]  pos_x_r, pos_y_r, size_w_r, size_h_r;
  logic [SCALE_W-1:0]  scale_r;

  // Captured request
  vpz_mode_t                  mode_r;
  logic signed [SCROLL_W-1:0] dx_r, dy_r;
  logic [SCENE_W-1:0]         fw_r, fh_r;
  logic                       zoom_ok_r;
  logic [SCALE_W-1:0]         next_scale_r;
  logic [SCENE_W-1:0]         nw_r, nh_r;

  // Result register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_free;

  vpz_div_req_t div_req;
  vpz_div_rsp_t div_rsp;

  logic                      in_acc;
  vpz_mode_t                 in_mode;
  logic [STEP_W-1:0]         in_step;
  logic signed [SCALE_W+1:0] next_in;
  logic                      zoom_in_ok;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_mode   = vpz_mode_t'(in_tuser);
  assign in_step   = in_tdata[29:22];
  assign out_free  = !out_tvalid_r || out_tready;

  // Zoom range check on the incoming step
  assign next_in    = $signed({2'b00, scale_r}) + $signed({{3{in_step[STEP_W-1]}}, in_step});
  assign zoom_in_ok = (next_in > $signed((SCALE_W+2)'(SCALE_LOW)))
                   && (next_in <= $signed((SCALE_W+2)'(SCALE_HIGH)));

  // Shared divider: width quotient first, then height
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = times100(screen_w_r);
    div_req.divisor  = next_in[SCALE_W-1:0];
    case (state_r)
      ST_IDLE: begin
        div_req.start = in_acc && (in_mode == MODE_ZOOM) && zoom_in_ok;
      end
      ST_DIVW: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = times100(screen_h_r);
        div_req.divisor  = next_scale_r;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  vpz_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = div_req.start ? ST_DIVW : ST_EXEC;
        end
      end
      ST_DIVW: begin
        if (div_rsp.done) state_nxt = ST_DIVH;
      end
      ST_DIVH: begin
        if (div_rsp.done) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Scroll: each axis moves only if it stays strictly inside the scene
  logic signed [SCENE_W+2:0] sx, sy, sx_end, sy_end;
  logic                      sx_ok, sy_ok;

  assign sx     = $signed({3'b000, pos_x_r}) + $signed({{6{dx_r[SCROLL_W-1]}}, dx_r});
  assign sy     = $signed({3'b000, pos_y_r}) + $signed({{6{dy_r[SCROLL_W-1]}}, dy_r});
  assign sx_end = sx + $signed({3'b000, size_w_r});
  assign sy_end = sy + $signed({3'b000, size_h_r});
  assign sx_ok  = (sx > 0) && (sx_end < $signed({3'b000, scene_w_r}));
  assign sy_ok  = (sy > 0) && (sy_end < $signed({3'b000, scene_h_r}));

  // Zoom: pull the origin back when the new window runs past an edge
  logic [SCENE_W:0]   zx_end, zy_end;
  logic               zx_over, zy_over, zoom_fail;
  logic [SCENE_W-1:0] zx, zy;

  assign zx_end    = {1'b0, pos_x_r} + {1'b0, nw_r};
  assign zy_end    = {1'b0, pos_y_r} + {1'b0, nh_r};
  assign zx_over   = zx_end > {1'b0, scene_w_r};
  assign zy_over   = zy_end > {1'b0, scene_h_r};
  assign zx        = zx_over ? (scene_w_r - nw_r) : pos_x_r;
  assign zy        = zy_over ? (scene_h_r - nh_r) : pos_y_r;
  assign zoom_fail = !zoom_ok_r || (zx_over && (nw_r > scene_w_r))
                                || (zy_over && (nh_r > scene_h_r));

  // Focus: center on the target, or center at its bottom
  logic [SCENE_W-1:0] fdx, fdy, fx, fy;

  assign fdx = fw_r - size_w_r;
  assign fdy = fh_r - size_h_r;
  assign fx  = (fw_r > size_w_r) ? (fdx >> 1) : '0;
  always_comb begin
    if (fh_r > size_h_r) begin
      fy = (mode_r == MODE_FOCUS_BOTTOM) ? fdy : (fdy >> 1);
    end else begin
      fy = '0;
    end
  end

  // Next viewport by event kind
  logic [SCENE_W-1:0] pos_x_nxt, pos_y_nxt, size_w_nxt, size_h_nxt;
  logic [SCALE_W-1:0] scale_nxt;
  logic               changed;

  always_comb begin
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    size_w_nxt = size_w_r;
    size_h_nxt = size_h_r;
    scale_nxt  = scale_r;
    case (mode_r)
      MODE_SCROLL: begin
        if (sx_ok) pos_x_nxt = sx[SCENE_W-1:0];
        if (sy_ok) pos_y_nxt = sy[SCENE_W-1:0];
      end
      MODE_ZOOM: begin
        if (!zoom_fail) begin
          pos_x_nxt  = zx;
          pos_y_nxt  = zy;
          size_w_nxt = nw_r;
          size_h_nxt = nh_r;
          scale_nxt  = next_scale_r;
        end
      end
      MODE_FOCUS, MODE_FOCUS_BOTTOM: begin
        pos_x_nxt = fx;
        pos_y_nxt = fy;
      end
      default: begin
        pos_x_nxt = pos_x_r;
      end
    endcase
  end

  assign changed = (pos_x_nxt != pos_x_r) || (pos_y_nxt != pos_y_r)
                || (size_w_nxt != size_w_r) || (size_h_nxt != size_h_r)
                || (scale_nxt != scale_r);

  // Control, configuration and viewport state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scene_w_r    <= SCENE_RST;
      scene_h_r    <= SCENE_RST;
      screen_w_r   <= SCREEN_W_RST;
      screen_h_r   <= SCREEN_H_RST;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      size_w_r     <= SIZE_RST;
      size_h_r     <= SIZE_RST;
      scale_r      <= SCALE_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (vpz_cfg_idx_t'(cfg_index))
          CFG_SCENE_WIDTH:   scene_w_r  <= cfg_data;
          CFG_SCENE_HEIGHT:  scene_h_r  <= cfg_data;
          CFG_SCREEN_WIDTH:  screen_w_r <= cfg_data[SCREEN_W-1:0];
          CFG_SCREEN_HEIGHT: screen_h_r <= cfg_data[SCREEN_W-1:0];
          default:           scene_w_r  <= scene_w_r;
        endcase
      end
      if (state_r == ST_EXEC && out_free) begin
        pos_x_r      <= pos_x_nxt;
        pos_y_r      <= pos_y_nxt;
        size_w_r     <= size_w_nxt;
        size_h_r     <= size_h_nxt;
        scale_r      <= scale_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Request capture, quotients and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r       <= in_mode;
      dx_r         <= in_tdata[10:0];
      dy_r         <= in_tdata[21:11];
      fw_r         <= in_tdata[43:30];
      fh_r         <= in_tdata[57:44];
      zoom_ok_r    <= zoom_in_ok;
      next_scale_r <= next_in[SCALE_W-1:0];
    end
    if (state_r == ST_DIVW && div_rsp.done) nw_r <= div_rsp.quotient[SCENE_W-1:0];
    if (state_r == ST_DIVH && div_rsp.done) nh_r <= div_rsp.quotient[SCENE_W-1:0];
    if (state_r == ST_EXEC && out_free) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, changed, scale_nxt,
                      size_h_nxt, size_w_nxt, pos_y_nxt, pos_x_nxt};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ sv/vpz_checker.sv @@
// ----------------------------------------------------------------------------
// vpz_checker: port-level checks for the viewport controller
// Watches the event and result streams and flags ordering slips.
// ----------------------------------------------------------------------------
module vpz_checker import vpz_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [1:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // One event at a time: busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // Scale reported always stays inside the zoom window
  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[64:56] > 9'd50) && (out_tdata[64:56] <= 9'd300))
    else $error("scale out of range");

  // Scroll and focus requests taken while no result is offered go through the update state to the result stream
  a_fast_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid && (in_tuser != MODE_ZOOM) |-> ##2 out_tvalid)
    else $error("scroll or focus result late");

endmodule

bind viewport_pan_zoom_clamp vpz_checker u_vpz_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
